### design/olst_pkg.sv
// ----------------------------------------------------------------------------
// olst_pkg
// Shared types and codes for the ordered list engine.
// ----------------------------------------------------------------------------
package olst_pkg;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_INSERT     = 3'd2,
    OP_DELETE     = 3'd3,
    OP_REVERSE    = 3'd4,
    OP_READ       = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2,
    STAT_RANGE = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD    = 2'd0,
    CELL_INSERT  = 2'd1,
    CELL_DELETE  = 2'd2,
    CELL_CAPTURE = 2'd3
  } cell_op_e;

  typedef enum logic [1:0] {
    FSM_IDLE = 2'd0,
    FSM_EXEC = 2'd1,
    FSM_WALK = 2'd2,
    FSM_RESP = 2'd3
  } fsm_e;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] value;
    logic [4:0] position;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [4:0] entry_count;
    logic [7:0] read_value;
  } rsp_t;

  // Broadcast from the sequencer to every cell
  typedef struct packed {
    cell_op_e   kind;
    logic [7:0] value;
  } cell_cmd_t;

endpackage

### design/olst_cell.sv
// ----------------------------------------------------------------------------
// olst_cell
// One list slot: holds an entry, shifts with its neighbors on insert and
// delete, and forwards read data along the pass chain every cycle.
// ----------------------------------------------------------------------------
module olst_cell #(
  parameter int unsigned IW  = 4,
  parameter int unsigned IDX = 0
) (
  input  logic               clk_i,
  input  olst_pkg::cell_cmd_t cmd_i,
  input  logic [IW-1:0]      idx_i,
  input  logic [7:0]         left_entry_i,
  input  logic [7:0]         right_entry_i,
  input  logic [7:0]         left_pass_i,
  output logic [7:0]         entry_o,
  output logic [7:0]         pass_o
);
  import olst_pkg::*;

  localparam logic [IW-1:0] MyIdx = IW'(IDX);

  logic [7:0] entry_q, entry_d;
  logic [7:0] pass_q, pass_d;

  always_comb begin
    entry_d = entry_q;
    pass_d  = left_pass_i;
    case (cmd_i.kind)
      CELL_INSERT: begin
        if (MyIdx > idx_i) begin
          entry_d = left_entry_i;
        end else if (MyIdx == idx_i) begin
          entry_d = cmd_i.value;
        end
      end
      CELL_DELETE: begin
        // close the gap: take the right neighbor's entry
        if (MyIdx >= idx_i) begin
          entry_d = right_entry_i;
        end
      end
      CELL_CAPTURE: begin
        if (MyIdx == idx_i) begin
          pass_d = entry_q;
        end
      end
      default: begin
        entry_d = entry_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
    pass_q  <= pass_d;
  end

  assign entry_o = entry_q;
  assign pass_o  = pass_q;

endmodule

### design/ordered_list_engine_unit.sv
// ----------------------------------------------------------------------------
// ordered_list_engine_unit
// Ordered byte list with push, insert, delete, reverse and read, held in a
// chain of cells with a direction flag for reversal.
// ----------------------------------------------------------------------------
//   channel  | signals                         | direction
//   request  | req_valid_i, req_ready_o, req_i | in
//   response | rsp_valid_o, rsp_ready_i, rsp_o | out
//
// Every request passes through the execute state and then the response state,
// where it waits for the output register to be free before it is answered.
// A read that finds its entry also passes through the walk state: the entry
// travels down the pass chain one cell per cycle to the last cell, and is
// latched from there into the result register.
// One request is in flight at a time; a finished response waits in the
// output register while the next request is taken.
// Reset clears the count, direction flag and control; entries need none.
// ----------------------------------------------------------------------------
module ordered_list_engine_unit #(
  parameter int unsigned DEPTH = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  output logic           req_ready_o,
  input  olst_pkg::req_t req_i,
  output logic           rsp_valid_o,
  input  logic           rsp_ready_i,
  output olst_pkg::rsp_t rsp_o
);
  import olst_pkg::*;

  localparam int unsigned IW   = $clog2(DEPTH);
  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned CMPW = (CW > 5) ? CW : 5;
  localparam logic [CMPW-1:0] DepthC = CMPW'(DEPTH);
  localparam logic [IW-1:0]   LastC  = IW'(DEPTH - 1);

  fsm_e            state_q, state_d;
  req_t            req_q;
  logic [CW-1:0]   count_q, count_d;
  logic            rev_q, rev_d;
  logic [IW-1:0]   walk_q, walk_d;
  rsp_t            res_q, res_d;
  logic            out_valid_q, out_valid_d;
  rsp_t            out_q, out_d;

  cell_cmd_t       cmd;
  logic [IW-1:0]   cmd_idx;
  logic [7:0]      entry [DEPTH];
  logic [7:0]      pass  [DEPTH];

  logic [CMPW-1:0] c_ext, p_ext, cnt_new_ext, phys_ext;
  status_e         status;
  logic            is_read_ok;

  // ---- cell chain ----------------------------------------------------------
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [7:0] left_entry, right_entry, left_pass;
    if (k == 0) begin : g_first
      assign left_entry = 8'h00;
      assign left_pass  = 8'h00;
    end else begin : g_mid
      assign left_entry = entry[k-1];
      assign left_pass  = pass[k-1];
    end
    if (k == DEPTH - 1) begin : g_last
      assign right_entry = entry[k];
    end else begin : g_inner
      assign right_entry = entry[k+1];
    end
    olst_cell #(
      .IW (IW),
      .IDX(k)
    ) u_cell (
      .clk_i        (clk_i),
      .cmd_i        (cmd),
      .idx_i        (cmd_idx),
      .left_entry_i (left_entry),
      .right_entry_i(right_entry),
      .left_pass_i  (left_pass),
      .entry_o      (entry[k]),
      .pass_o       (pass[k])
    );
  end

  // ---- request decode ------------------------------------------------------
  assign c_ext = CMPW'(count_q);
  assign p_ext = CMPW'(req_q.position);

  // With the direction flag set, logical index i sits at physical count-1-i
  // and a new entry at logical i lands at physical count-i.
  always_comb begin
    status     = STAT_OK;
    phys_ext   = '0;
    is_read_ok = 1'b0;
    case (op_e'(req_q.op))
      OP_PUSH_FRONT: begin
        if (c_ext >= DepthC) status = STAT_FULL;
        phys_ext = rev_q ? c_ext : '0;
      end
      OP_PUSH_BACK: begin
        if (c_ext >= DepthC) status = STAT_FULL;
        phys_ext = rev_q ? '0 : c_ext;
      end
      OP_INSERT: begin
        if (c_ext >= DepthC) begin
          status = STAT_FULL;
        end else if (p_ext > c_ext) begin
          status = STAT_RANGE;
        end
        phys_ext = rev_q ? (c_ext - p_ext) : p_ext;
      end
      OP_DELETE: begin
        if (c_ext == '0) begin
          status = STAT_EMPTY;
        end else if (p_ext == '0 || p_ext > c_ext) begin
          status = STAT_RANGE;
        end
        phys_ext = rev_q ? (c_ext - p_ext) : (p_ext - CMPW'(1));
      end
      OP_REVERSE: begin
        if (c_ext == '0) status = STAT_EMPTY;
      end
      OP_READ: begin
        if (c_ext == '0) begin
          status = STAT_EMPTY;
        end else if (p_ext >= c_ext) begin
          status = STAT_RANGE;
        end else begin
          is_read_ok = 1'b1;
        end
        phys_ext = rev_q ? (c_ext - p_ext - CMPW'(1)) : p_ext;
      end
      default: begin
        status = STAT_OK;
      end
    endcase
  end

  // ---- sequencer -----------------------------------------------------------
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    rev_d       = rev_q;
    walk_d      = walk_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    cmd.kind    = CELL_HOLD;
    cmd.value   = req_q.value;
    cmd_idx     = phys_ext[IW-1:0];
    cnt_new_ext = c_ext;

    // drop the response once taken
    if (out_valid_q && rsp_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      FSM_IDLE: begin
        if (req_valid_i) state_d = FSM_EXEC;
      end
      FSM_EXEC: begin
        if (status == STAT_OK) begin
          case (op_e'(req_q.op))
            OP_PUSH_FRONT, OP_PUSH_BACK, OP_INSERT: begin
              cmd.kind    = CELL_INSERT;
              cnt_new_ext = c_ext + CMPW'(1);
            end
            OP_DELETE: begin
              cmd.kind    = CELL_DELETE;
              cnt_new_ext = c_ext - CMPW'(1);
            end
            OP_REVERSE: begin
              rev_d = ~rev_q;
            end
            OP_READ: begin
              cmd.kind = CELL_CAPTURE;
            end
            default: begin
              cmd.kind = CELL_HOLD;
            end
          endcase
        end
        count_d           = cnt_new_ext[CW-1:0];
        res_d.status      = status;
        res_d.entry_count = cnt_new_ext[4:0];
        res_d.read_value  = 8'h00;
        walk_d            = LastC - phys_ext[IW-1:0];
        state_d           = is_read_ok ? FSM_WALK : FSM_RESP;
      end
      FSM_WALK: begin
        // the captured entry advances one cell per cycle
        if (walk_q == '0) begin
          res_d.read_value = pass[DEPTH-1];
          state_d          = FSM_RESP;
        end else begin
          walk_d = walk_q - IW'(1);
        end
      end
      FSM_RESP: begin
        if (!out_valid_q || rsp_ready_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = FSM_IDLE;
        end
      end
      default: begin
        state_d = FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      count_q     <= '0;
      rev_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rev_q       <= rev_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == FSM_IDLE && req_valid_i) begin
      req_q <= req_i;
    end
    walk_q <= walk_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

  assign req_ready_o = (state_q == FSM_IDLE);
  assign rsp_valid_o = out_valid_q;
  assign rsp_o       = out_q;

endmodule
